// ===== rtl/core/kwmpq_pkg.sv =====
// Shared types, codes and the ordering function of the k-way merge priority queue.
// Used by kwmpq_cell and kway_merge_max_priority_queue_core; depends on nothing.
package kwmpq_pkg;

   // Number of records the queue can hold.
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 5;

   // Operation carried in req_tuser.
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Status carried in rsp_tuser.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One record; the key sits in the lowest bits of the packed vector.
   typedef struct packed {
      logic [3:0]  stream;
      logic [30:0] position;
      logic [7:0]  chromosome;
      logic [30:0] row;
      logic [63:0] key;
   } record_type;

   localparam int REC_W = $bits(record_type);

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
   } ctrl_type;

   // True when record a must leave the queue before record b.
   // Equal keys go to the lower stream; fully equal records keep arrival order.
   function automatic logic rec_beats(input record_type a, input record_type b);
      rec_beats = (a.key > b.key) || ((a.key == b.key) && (a.stream < b.stream));
   endfunction

endpackage

// ===== rtl/core/kwmpq_cell.sv =====
// One slot of the sorted shift-register chain of the priority queue.
// Depends on kwmpq_pkg for the record type, the command struct and rec_beats.
module kwmpq_cell import kwmpq_pkg::*; (
   input  logic       clock,
   input  ctrl_type   ctrl,
   input  record_type new_rec,
   input  record_type left_rec,
   input  logic       left_beaten,
   input  record_type right_rec,
   input  logic       valid,
   output record_type rec,
   output logic       beaten
);

   record_type rec_ff;
   record_type rec_in;

   // The incoming record belongs at or before this slot when the slot is empty
   // or the incoming record outranks the one held here.
   assign beaten = !valid || rec_beats(new_rec, rec_ff);
   assign rec    = rec_ff;

   // Insert shifts the tail right by one; removal shifts everything left.
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.push && beaten) begin
         if (left_beaten) begin
            rec_in = left_rec;
         end else begin
            rec_in = new_rec;
         end
      end else if (ctrl.pop) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== rtl/core/kway_merge_max_priority_queue_core.sv =====
// Top level of the k-way merge max-priority queue: request/response channels,
// fill count and the chain of kwmpq_cell slots. Depends on kwmpq_pkg and kwmpq_cell.
//
// Usage:
//   Each request transfer on req_* is one operation. req_tuser selects push (0) or
//   pop (1); req_tdata carries the record for a push and is ignored for a pop.
//   Every request gives exactly one response transfer on rsp_*: rsp_tuser is the
//   status (ok, pop on empty, push on full), rsp_tdata the popped record (zero
//   on a push or a failed pop) and the occupancy after the operation.
//   A push on a full queue drops the record; a pop on an empty queue changes nothing.
// Latency and throughput:
//   The response is registered and appears in the cycle after the request transfer.
//   One operation is taken every cycle unless a held response stalls the input: the
//   records are held in sorted order in a chain of cells, each comparing the new
//   record with its own in the same cycle.
// Reset: synchronous; it empties the queue and drops any held response.
// Stall:
//   While rsp_tvalid is high and rsp_tready low, req_tready is low and the held
//   response stays unchanged; a new request is taken in the cycle the response leaves.
module kway_merge_max_priority_queue_core import kwmpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: sort_key[63:0], row_number[30:0], chromosome[7:0],
   // position[30:0], stream_id[3:0], zero fill.
   input  logic [143:0] req_tdata,
   // Fields from bit 0: op.
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: out_key[63:0], out_row[30:0], out_chromosome[7:0],
   // out_position[30:0], out_stream[3:0], occupancy[4:0], zero fill.
   output logic [143:0] rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]   rsp_tuser
);

   logic             req_accept;
   logic             is_pop;
   logic             full;
   logic             empty;
   logic             push_ok;
   logic             pop_ok;
   ctrl_type         ctrl;
   record_type       new_rec;
   record_type       cell_rec    [CAPACITY];
   logic             cell_beaten [CAPACITY];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   record_type       rsp_rec_ff;
   record_type       rsp_rec_in;
   status_type       rsp_status_ff;
   status_type       rsp_status_in;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic [OCC_W-1:0] rsp_occ_in;

   // Request decode.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign is_pop     = (op_type'(req_tuser[0]) == OP_POP);
   assign new_rec    = record_type'(req_tdata[REC_W-1:0]);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign push_ok    = req_accept && !is_pop && !full;
   assign pop_ok     = req_accept && is_pop && !empty;
   assign ctrl.push  = push_ok;
   assign ctrl.pop   = pop_ok;

   // Sorted chain: cell 0 holds the record that leaves next.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      record_type left_rec;
      record_type right_rec;
      logic       left_beaten;

      if (i == 0) begin : g_head
         assign left_rec    = new_rec;
         assign left_beaten = 1'b0;
      end else begin : g_body
         assign left_rec    = cell_rec[i-1];
         assign left_beaten = cell_beaten[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_rec = cell_rec[i];
      end else begin : g_inner
         assign right_rec = cell_rec[i+1];
      end

      kwmpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_rec     (new_rec),
         .left_rec    (left_rec),
         .left_beaten (left_beaten),
         .right_rec   (right_rec),
         .valid       (count_ff > CNT_W'(i)),
         .rec         (cell_rec[i]),
         .beaten      (cell_beaten[i])
      );
   end

   // Fill count and response register.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_occ_in   = OCC_W'(count_in);
         rsp_rec_in   = '0;
         if (pop_ok) begin
            rsp_rec_in    = cell_rec[0];
            rsp_status_in = ST_OK;
         end else if (is_pop) begin
            rsp_status_in = ST_EMPTY;
         end else if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rec_ff    <= rsp_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(144 - REC_W - OCC_W){1'b0}}, rsp_occ_ff, rsp_rec_ff};

`ifndef NO_ASSERTIONS
   // The fill count never passes the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // A successful push grows the queue by exactly one entry.
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      push_ok |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not add one entry");

   // The head of the chain is never outranked by its successor.
   a_head_order : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> !rec_beats(cell_rec[1], cell_rec[0]))
      else $error("chain head out of order");

   // A pop on empty reports an empty queue.
   a_empty_occ : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EMPTY)) |-> (rsp_occ_ff == '0))
      else $error("empty status with nonzero occupancy");
`endif

endmodule

// ===== sim/tb_kway_merge_max_priority_queue_core.sv =====
// Self-checking testbench for the k-way merge max-priority queue core.
// Predicts every response from its own record list; depends on kwmpq_pkg and
// kway_merge_max_priority_queue_core.
module tb_kway_merge_max_priority_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   import kwmpq_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 120;
   localparam int HOLD_ITEMS   = 40;
   localparam int RANDOM_ITEMS = 790;
   localparam int DRAIN_CYCLES = 4;
   localparam int PRINT_LIMIT  = 40;
   localparam int DATA_W       = 144;
   localparam logic [63:0] TIE_KEY = 64'h8000_0000_0000_0000;

   // One response as the queue should produce it.
   typedef struct {
      status_type       status;
      record_type       rec;
      logic [OCC_W-1:0] occ;
   } pq_response_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic [0:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;

   // Predictor state: records held, in arrival order, and responses still owed.
   record_type      held_records[$];
   pq_response_type expected_responses[$];

   int error_count       = 0;
   int responses_checked = 0;
   int stored_count      = 0;
   int full_count        = 0;
   int popped_count      = 0;
   int empty_count       = 0;
   int burst_left        = 0;
   int idle_cycles       = 0;

   // Receiver pattern state; hold_asked is bumped by the tests, the rest is
   // owned by the receiver process.
   int hold_asked  = 0;
   int hold_taken  = 0;
   int hold_left   = 0;
   int stall_pct   = 0;
   int window_left = 0;

   always #CLK_HALF clock = ~clock;

   kway_merge_max_priority_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Apply one operation to the predicted queue and return the response it gives.
   function automatic pq_response_type predict_queue_op(input op_type op,
                                                        input record_type rec);
      pq_response_type resp;
      int              best;
      int              i;
      resp.status = ST_OK;
      resp.rec    = '0;
      if (op == OP_PUSH) begin
         if (held_records.size() >= CAPACITY) begin
            resp.status = ST_FULL;
            full_count++;
         end else begin
            held_records.insert(held_records.size(), rec);
            stored_count++;
         end
      end else if (held_records.size() == 0) begin
         resp.status = ST_EMPTY;
         empty_count++;
      end else begin
         // Largest key wins; on equal keys the lower stream, then the earlier arrival.
         best = 0;
         for (i = 1; i < held_records.size(); i++) begin
            if (held_records[i].key > held_records[best].key ||
                (held_records[i].key == held_records[best].key &&
                 held_records[i].stream < held_records[best].stream))
               best = i;
         end
         resp.rec = held_records[best];
         held_records.delete(best);
         popped_count++;
      end
      resp.occ = OCC_W'(held_records.size());
      return resp;
   endfunction

   function automatic record_type make_record(input logic [63:0] key, input logic [30:0] row,
                                              input logic [7:0] chromosome,
                                              input logic [30:0] position,
                                              input logic [3:0] stream);
      record_type rec;
      rec.key        = key;
      rec.row        = row;
      rec.chromosome = chromosome;
      rec.position   = position;
      rec.stream     = stream;
      return rec;
   endfunction

   // Random record; a good share of keys land in a tiny set so that ties are common.
   function automatic record_type random_record();
      record_type rec;
      case ($urandom_range(0, 3))
         0: rec.key = {$urandom, $urandom};
         1: rec.key = 64'h3FF0_0000_0000_0000 + 64'($urandom_range(0, 3));
         2: begin
            case ($urandom_range(0, 2))
               0: rec.key = '0;
               1: rec.key = '1;
               default: rec.key = TIE_KEY;
            endcase
         end
         default: rec.key = {32'h0, $urandom} << $urandom_range(0, 32);
      endcase
      rec.row        = 31'($urandom);
      rec.chromosome = 8'($urandom_range(0, 255));
      rec.position   = 31'($urandom);
      rec.stream     = 4'($urandom_range(0, 15));
      return rec;
   endfunction

   // Offer one request in bursts with random gaps, wait for its transfer, predict it.
   task automatic send_op(input op_type op, input record_type rec);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(DATA_W - REC_W){1'b0}}, rec};
      do @(posedge clock); while (!(req_tvalid === 1'b1 && req_tready === 1'b1));
      expected_responses.insert(expected_responses.size(), predict_queue_op(op, rec));
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("response %0d: %s is 0x%0h, expected 0x%0h",
                  responses_checked, what, got, want);
   endtask

   // Receiver: stall density changes per window, with an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (window_left == 0) begin
         window_left = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 15;
            2: stall_pct = 40;
            default: stall_pct = 75;
         endcase
      end
      window_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      pq_response_type want;
      record_type      got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata[REC_W-1:0];
         if (expected_responses.size() == 0) begin
            report_mismatch("response with no request", rsp_tdata[63:0], '0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            if (got.key !== want.rec.key)
               report_mismatch("key", got.key, want.rec.key);
            if (got.row !== want.rec.row)
               report_mismatch("row", 64'(got.row), 64'(want.rec.row));
            if (got.chromosome !== want.rec.chromosome)
               report_mismatch("chromosome", 64'(got.chromosome),
                               64'(want.rec.chromosome));
            if (got.position !== want.rec.position)
               report_mismatch("position", 64'(got.position), 64'(want.rec.position));
            if (got.stream !== want.rec.stream)
               report_mismatch("stream", 64'(got.stream), 64'(want.rec.stream));
            if (rsp_tdata[REC_W +: OCC_W] !== want.occ)
               report_mismatch("occupancy", 64'(rsp_tdata[REC_W +: OCC_W]), 64'(want.occ));
            if (rsp_tdata[DATA_W-1:REC_W+OCC_W] !== '0)
               report_mismatch("fill bits", 64'(rsp_tdata[DATA_W-1:REC_W+OCC_W]), '0);
         end
         responses_checked++;
      end
   end

   // Watchdog: end the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d responses still owed",
                  idle_cycles, expected_responses.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_pop_on_empty();
      send_op(OP_POP, random_record());
   endtask

   // Fill the queue to capacity with field extremes and three kinds of key ties.
   task automatic test_fill_with_extremes();
      record_type rec;
      int         n;
      send_op(OP_PUSH, make_record('1, 31'd1, 8'd1, 31'd1, 4'd15));
      send_op(OP_PUSH, make_record('0, '0, '0, '0, 4'd0));
      send_op(OP_PUSH, make_record('1, '1, '1, '1, 4'd0));
      send_op(OP_PUSH, make_record(TIE_KEY, 31'd10, 8'd22, 31'd1000, 4'd5));
      send_op(OP_PUSH, make_record(TIE_KEY, 31'd11, 8'd23, 31'd2000, 4'd3));
      send_op(OP_PUSH, make_record(TIE_KEY, 31'd12, 8'd24, 31'd3000, 4'd5));
      send_op(OP_PUSH, make_record(64'h7FFF_FFFF_FFFF_FFFF, 31'd13, 8'd7, 31'd7, 4'd7));
      for (n = 0; n < CAPACITY - 7; n++) begin
         rec = random_record();
         rec.key[63] = 1'b0;
         send_op(OP_PUSH, rec);
      end
   endtask

   // A refused record would outrank the tied entries and show up in the pops below.
   task automatic test_push_on_full();
      send_op(OP_PUSH, make_record(TIE_KEY + 64'd1, 31'd99, 8'd99, 31'd99, 4'd0));
   endtask

   task automatic test_pop_order_and_ties();
      repeat (6) send_op(OP_POP, random_record());
   endtask

   // Hold the receiver off while requests keep coming, so the input side stalls.
   task automatic test_input_stall_under_backpressure();
      int n;
      hold_asked <= hold_asked + 1;
      for (n = 0; n < HOLD_ITEMS; n++)
         send_op(($urandom_range(0, 1) == 1) ? OP_POP : OP_PUSH, random_record());
   endtask

   // Segments with different push shares walk the queue between empty and full.
   task automatic test_random_traffic(input int item_count);
      int     n;
      int     seg_left;
      int     push_pct;
      op_type op;
      seg_left = 0;
      push_pct = 50;
      for (n = 0; n < item_count; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 60);
            case ($urandom_range(0, 4))
               0: push_pct = 10;
               1: push_pct = 35;
               2: push_pct = 55;
               3: push_pct = 80;
               default: push_pct = 95;
            endcase
         end
         seg_left--;
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         send_op(op, random_record());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_pop_on_empty();
      test_fill_with_extremes();
      test_push_on_full();
      test_pop_order_and_ties();
      test_input_stall_under_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      // Let the last responses drain, then watch a few quiet cycles.
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d operations: %0d stored, %0d refused on full, %0d popped, %0d empty pops.",
               stored_count + full_count + popped_count + empty_count,
               stored_count, full_count, popped_count, empty_count);
      $display("Checked %0d responses, including a %0d-cycle receiver hold-off; %0d mismatches.",
               responses_checked, HOLD_CYCLES, error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== kway_merge_max_priority_queue_core.f =====
rtl/core/kwmpq_pkg.sv
rtl/core/kwmpq_cell.sv
rtl/core/kway_merge_max_priority_queue_core.sv
sim/tb_kway_merge_max_priority_queue_core.sv
